>>> src/rbp_pkg.sv
// ---------------------------------------------------------------------------
// rbp_pkg: shared types and constants for the ray bounce path block
// Register indexes, reset values, rail hit codes and port types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbp_pkg;

    // port types
    typedef logic signed [15:0] t_coord16;
    typedef logic        [2:0]  t_cfg_idx;
    typedef logic        [15:0] t_cfg_data;
    typedef logic        [2:0]  t_seg_num;

    // configuration register indexes
    localparam t_cfg_idx CFG_RAIL_LEFT   = 3'd0;
    localparam t_cfg_idx CFG_RAIL_RIGHT  = 3'd1;
    localparam t_cfg_idx CFG_RAIL_TOP    = 3'd2;
    localparam t_cfg_idx CFG_RAIL_BOTTOM = 3'd3;
    localparam t_cfg_idx CFG_GAIN        = 3'd4;
    localparam t_cfg_idx CFG_SPEED_LIMIT = 3'd5;
    localparam t_cfg_idx CFG_PREVIEW     = 3'd6;

    // register reset values
    localparam logic signed [15:0] RST_RAIL_LEFT   = 16'sd0;
    localparam logic signed [15:0] RST_RAIL_RIGHT  = 16'sd16383;
    localparam logic signed [15:0] RST_RAIL_TOP    = 16'sd0;
    localparam logic signed [15:0] RST_RAIL_BOTTOM = 16'sd8191;
    localparam logic        [11:0] RST_GAIN        = 12'd256;
    localparam logic        [15:0] RST_SPEED_LIMIT = 16'd16000;

    // rail hit codes
    typedef logic [2:0] t_hit;
    localparam t_hit HIT_NONE   = 3'd0;
    localparam t_hit HIT_LEFT   = 3'd1;
    localparam t_hit HIT_RIGHT  = 3'd2;
    localparam t_hit HIT_TOP    = 3'd3;
    localparam t_hit HIT_BOTTOM = 3'd4;

    // divider result destinations
    typedef logic [1:0] t_dst;
    localparam t_dst DST_CX = 2'd2;
    localparam t_dst DST_CY = 2'd3;

endpackage

`default_nettype wire

>>> src/ray_bounce_path_in_box.sv
// ---------------------------------------------------------------------------
// ray_bounce_path_in_box: billiard shot path with rail reflections
// Computes the shot segments of a ball in a railed box, one segment per
// output request, using one shared multiplier and one bit-serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a start and an aim point.
//   Output channel (o_out_valid / i_out_stall) carries one request per path
//   segment, in order; the final one has o_last_segment set.
//   The plain write port sets rails, gain, speed limit and preview enable;
//   write it only while the block is idle. With preview off a request is
//   taken and dropped.
// Sequence (IW = internal coordinate width, 16 by default, QW = IW + 3):
//   an over-speed test, the first end point (rounded shift), then for
//   each segment a rail classification, a rail clip division with QW
//   quotient bits where the clip needs one, and the output request. A
//   path has at most eight segments at the default MAX_SEGMENTS.
// One request is handled at a time; o_in_stall is high until the last
// segment has been taken. A stalled output holds the block in place.
// Reset (synchronous, active low) restores register defaults and idles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_bounce_path_in_box #(
    parameter int MAX_SEGMENTS = 8,
    parameter int COORD_BITS   = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration
    input  wire                 i_cfg_we,
    input  rbp_pkg::t_cfg_idx   i_cfg_idx,
    input  rbp_pkg::t_cfg_data  i_cfg_data,
    // input channel
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rbp_pkg::t_coord16   i_start_x,
    input  rbp_pkg::t_coord16   i_start_y,
    input  rbp_pkg::t_coord16   i_aim_x,
    input  rbp_pkg::t_coord16   i_aim_y,
    // output channel
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rbp_pkg::t_coord16   o_seg_start_x,
    output rbp_pkg::t_coord16   o_seg_start_y,
    output rbp_pkg::t_coord16   o_seg_end_x,
    output rbp_pkg::t_coord16   o_seg_end_y,
    output rbp_pkg::t_seg_num   o_segment_number,
    output logic                o_over_speed,
    output logic                o_last_segment
);
    import rbp_pkg::*;

    // widths
    localparam int IW  = (COORD_BITS < 12) ? 12 : ((COORD_BITS > 30) ? 30 : COORD_BITS);
    localparam int SEG_LIMIT = (MAX_SEGMENTS < 1) ? 1 : ((MAX_SEGMENTS > 8) ? 8 : MAX_SEGMENTS);
    localparam int DW  = IW + 1;
    localparam int MW  = (DW > 25) ? DW : 25;
    localparam int PW  = 2 * MW;
    localparam int NW  = PW + 1;
    localparam int QW  = IW + 3;
    localparam int SW  = QW + 2;
    localparam int CW  = $clog2(QW + 1);
    localparam int OVW = 60;
    localparam int OW  = ((IW > 16) ? IW : 16) + 1;

    localparam logic signed [SW-1:0] W_HI = SW'((64'sd1 <<< (IW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] W_LO = -W_HI - SW'(1);
    localparam logic signed [OW-1:0] O_HI = OW'(32767);
    localparam logic signed [OW-1:0] O_LO = -O_HI - OW'(1);
    localparam logic [2:0] LAST_K = 3'(SEG_LIMIT - 1);

    // state codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PX2  = 5'd1;
    localparam logic [4:0] S_PY2  = 5'd2;
    localparam logic [4:0] S_G2   = 5'd3;
    localparam logic [4:0] S_GLO  = 5'd4;
    localparam logic [4:0] S_GHI  = 5'd5;
    localparam logic [4:0] S_LIM  = 5'd6;
    localparam logic [4:0] S_OVC  = 5'd7;
    localparam logic [4:0] S_EXM  = 5'd8;
    localparam logic [4:0] S_EYM  = 5'd9;
    localparam logic [4:0] S_CLS  = 5'd10;
    localparam logic [4:0] S_CP   = 5'd11;
    localparam logic [4:0] S_CQL  = 5'd12;
    localparam logic [4:0] S_CCL  = 5'd13;
    localparam logic [4:0] S_CCR  = 5'd14;
    localparam logic [4:0] S_CLIP = 5'd15;
    localparam logic [4:0] S_DIVI = 5'd16;
    localparam logic [4:0] S_DIVR = 5'd17;
    localparam logic [4:0] S_DIVD = 5'd18;
    localparam logic [4:0] S_EMIT = 5'd19;
    localparam logic [4:0] S_WAIT = 5'd20;
    localparam logic [4:0] S_EXD  = 5'd21;
    localparam logic [4:0] S_EYD  = 5'd22;

    function automatic logic signed [IW-1:0] sat_w(input logic signed [SW-1:0] v);
        if (v > W_HI) begin
            return W_HI[IW-1:0];
        end else if (v < W_LO) begin
            return W_LO[IW-1:0];
        end
        return v[IW-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [IW-1:0] v);
        logic signed [OW-1:0] e;
        e = OW'(v);
        if (e > O_HI) begin
            return O_HI[15:0];
        end else if (e < O_LO) begin
            return O_LO[15:0];
        end
        return e[15:0];
    endfunction

    // configuration registers
    logic signed [15:0] r_rail_left, r_rail_right, r_rail_top, r_rail_bottom;
    logic [11:0]        r_gain;
    logic [15:0]        r_speed_limit;
    logic               r_preview;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rail_left   <= RST_RAIL_LEFT;
            r_rail_right  <= RST_RAIL_RIGHT;
            r_rail_top    <= RST_RAIL_TOP;
            r_rail_bottom <= RST_RAIL_BOTTOM;
            r_gain        <= RST_GAIN;
            r_speed_limit <= RST_SPEED_LIMIT;
            r_preview     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RAIL_LEFT:   r_rail_left   <= i_cfg_data;
                CFG_RAIL_RIGHT:  r_rail_right  <= i_cfg_data;
                CFG_RAIL_TOP:    r_rail_top    <= i_cfg_data;
                CFG_RAIL_BOTTOM: r_rail_bottom <= i_cfg_data;
                CFG_GAIN:        r_gain        <= i_cfg_data[11:0];
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_PREVIEW:     r_preview     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // rails at internal width
    logic signed [IW-1:0] c_l, c_r, c_t, c_b;
    assign c_l = sat_w(SW'(r_rail_left));
    assign c_r = sat_w(SW'(r_rail_right));
    assign c_t = sat_w(SW'(r_rail_top));
    assign c_b = sat_w(SW'(r_rail_bottom));

    // datapath registers
    logic [4:0]           r_state;
    logic signed [IW-1:0] r_sx, r_sy, r_ex, r_ey, r_cx, r_cy, r_rx, r_ry;
    logic signed [IW-1:0] r_rail_tb;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [16:0]   r_px, r_py;
    logic signed [PW-1:0] r_prod, r_p;
    logic [OVW-1:0]       r_acc;
    logic [33:0]          r_len2;
    logic [23:0]          r_g2;
    logic                 r_over, r_last;
    logic [2:0]           r_k;
    t_hit                 r_hit;
    t_dst                 r_dst;
    // divider registers
    logic [DW-1:0]        r_dud, r_drem;
    logic [QW-1:0]        r_dlow, r_dq;
    logic [CW-1:0]        r_dcnt;
    logic                 r_dneg, r_dovf;
    // output registers
    logic                 r_ovalid;
    logic signed [15:0]   r_osx, r_osy, r_oex, r_oey;
    logic [2:0]           r_ok;
    logic                 r_oover, r_olast;

    // differences for products
    logic signed [DW-1:0] w_tb_sy, w_l_sx, w_r_sx, w_rs_sx;
    logic signed [DW-1:0] w_dx, w_dy;
    logic signed [IW-1:0] w_rail_s;
    assign w_rail_s = (r_hit == HIT_LEFT) ? c_l : c_r;
    assign w_tb_sy  = DW'(r_rail_tb) - DW'(r_sy);
    assign w_l_sx   = DW'(c_l) - DW'(r_sx);
    assign w_r_sx   = DW'(c_r) - DW'(r_sx);
    assign w_rs_sx  = DW'(w_rail_s) - DW'(r_sx);
    assign w_dx     = DW'(r_ex) - DW'(r_sx);
    assign w_dy     = DW'(r_ey) - DW'(r_sy);

    // shared multiplier operand select
    logic signed [MW-1:0] m_a, m_b;
    logic signed [PW-1:0] w_prod;
    logic                 w_side;
    assign w_side = (r_hit == HIT_LEFT) || (r_hit == HIT_RIGHT);

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_PX2: begin m_a = MW'(r_px); m_b = MW'(r_px); end
            S_PY2: begin m_a = MW'(r_py); m_b = MW'(r_py); end
            S_G2:  begin m_a = MW'(r_gain); m_b = MW'(r_gain); end
            S_GLO: begin m_a = MW'(r_prod[23:0]); m_b = MW'(r_len2[16:0]); end
            S_GHI: begin m_a = MW'(r_g2); m_b = MW'(r_len2[33:17]); end
            S_LIM: begin
                m_a = MW'({r_speed_limit, 8'd0});
                m_b = MW'({r_speed_limit, 8'd0});
            end
            S_EXM: begin m_a = MW'(r_gain); m_b = MW'(r_px); end
            S_EYM: begin m_a = MW'(r_gain); m_b = MW'(r_py); end
            S_CP:  begin m_a = MW'(w_tb_sy); m_b = MW'(r_dx); end
            S_CQL: begin m_a = MW'(w_l_sx); m_b = MW'(r_dy); end
            S_CCL: begin m_a = MW'(w_r_sx); m_b = MW'(r_dy); end
            S_CLIP: begin
                if (w_side) begin
                    m_a = MW'(w_rs_sx);
                    m_b = MW'(r_dy);
                end else begin
                    m_a = MW'(w_tb_sy);
                    m_b = MW'(r_dx);
                end
            end
            default: ;
        endcase
    end
    assign w_prod = m_a * m_b;

    // classification compares
    logic w_top, w_bot, w_lft, w_rgt;
    assign w_top = r_ey < c_t;
    assign w_bot = r_ey > c_b;
    assign w_lft = r_ex < c_l;
    assign w_rgt = r_ex > c_r;

    // cross-multiplied intercept test against side rails
    logic w_cross_l, w_cross_r;
    assign w_cross_l = r_dy[DW-1] ? (r_prod < r_p) : (r_p < r_prod);
    assign w_cross_r = r_dy[DW-1] ? (r_p < r_prod) : (r_prod < r_p);

    // divider setup
    logic signed [DW-1:0] w_den;
    logic [PW-1:0]        w_un;
    logic [DW-1:0]        w_ud;
    logic [NW-1:0]        w_n;
    always_comb begin
        case (r_dst)
            DST_CY:  w_den = r_dx;
            default: w_den = r_dy;
        endcase
    end
    assign w_un = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign w_ud = w_den[DW-1] ? DW'(-w_den) : DW'(w_den);
    assign w_n  = NW'(w_un) + NW'(w_ud >> 1);

    // gain scaling: rounded shift by 8 bits (divide by 256), halves away from zero
    logic [PW-1:0]        w_scl;
    logic [QW-1:0]        w_smag;
    logic signed [QW:0]   w_sq;
    logic signed [IW-1:0] w_gbase, w_gupd;
    assign w_scl   = (w_un + PW'(128)) >> 8;
    assign w_smag  = ((w_scl >> QW) != '0) ? '1 : w_scl[QW-1:0];
    assign w_sq    = r_prod[PW-1] ? -$signed({1'b0, w_smag}) : $signed({1'b0, w_smag});
    assign w_gbase = (r_state == S_EYD) ? r_sy : r_sx;
    assign w_gupd  = sat_w(SW'(w_gbase) + SW'(w_sq));

    // divider step
    logic [DW:0] w_rem2;
    logic        w_ge;
    assign w_rem2 = {r_drem, r_dlow[QW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_dud};

    // signed quotient and target update
    logic [QW-1:0]        w_qmag;
    logic signed [QW:0]   w_q;
    logic signed [IW-1:0] w_base, w_upd;
    assign w_qmag = r_dovf ? '1 : r_dq;
    assign w_q    = r_dneg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
    assign w_base = (r_dst == DST_CX) ? r_sx : r_sy;
    assign w_upd  = sat_w(SW'(w_base) + SW'(w_q));

    // sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sx  <= sat_w(SW'(i_start_x));
                        r_sy  <= sat_w(SW'(i_start_y));
                        r_px  <= 17'(i_start_x) - 17'(i_aim_x);
                        r_py  <= 17'(i_start_y) - 17'(i_aim_y);
                        r_k   <= '0;
                        if (r_preview) begin
                            r_state <= S_PX2;
                        end
                    end
                end
                // over-speed test from squares
                S_PX2: r_state <= S_PY2;
                S_PY2: begin
                    r_acc   <= OVW'(r_prod);
                    r_state <= S_G2;
                end
                S_G2: begin
                    r_len2  <= 34'(r_acc + OVW'(r_prod));
                    r_state <= S_GLO;
                end
                S_GLO: begin
                    r_g2    <= r_prod[23:0];
                    r_state <= S_GHI;
                end
                S_GHI: begin
                    r_acc   <= OVW'(r_prod);
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_acc   <= r_acc + (OVW'(r_prod) << 17);
                    r_state <= S_OVC;
                end
                S_OVC: begin
                    r_over  <= r_acc >= OVW'(r_prod);
                    r_state <= S_EXM;
                end
                // first end point
                S_EXM: r_state <= S_EXD;
                S_EXD: begin
                    r_ex    <= w_gupd;
                    r_state <= S_EYM;
                end
                S_EYM: r_state <= S_EYD;
                S_EYD: begin
                    r_ey    <= w_gupd;
                    r_state <= S_CLS;
                end
                // rail classification
                S_CLS: begin
                    r_dx <= w_dx;
                    r_dy <= w_dy;
                    r_rail_tb <= w_top ? c_t : c_b;
                    if (w_top || w_bot) begin
                        if (w_dy != '0) begin
                            r_hit   <= w_top ? HIT_TOP : HIT_BOTTOM;
                            r_state <= S_CP;
                        end else begin
                            if (w_lft) begin
                                r_hit <= HIT_LEFT;
                            end else if (w_rgt) begin
                                r_hit <= HIT_RIGHT;
                            end else begin
                                r_hit <= w_top ? HIT_TOP : HIT_BOTTOM;
                            end
                            r_state <= S_CLIP;
                        end
                    end else if (w_lft || w_rgt) begin
                        r_hit   <= w_lft ? HIT_LEFT : HIT_RIGHT;
                        r_state <= S_CLIP;
                    end else begin
                        r_hit   <= HIT_NONE;
                        r_cx    <= r_ex;
                        r_cy    <= r_ey;
                        r_last  <= 1'b1;
                        r_state <= S_EMIT;
                    end
                end
                S_CP:  r_state <= S_CQL;
                S_CQL: begin
                    r_p     <= r_prod;
                    r_state <= S_CCL;
                end
                S_CCL: begin
                    if (w_cross_l) begin
                        r_hit   <= HIT_LEFT;
                        r_state <= S_CLIP;
                    end else begin
                        r_state <= S_CCR;
                    end
                end
                S_CCR: begin
                    if (w_cross_r) begin
                        r_hit <= HIT_RIGHT;
                    end
                    r_state <= S_CLIP;
                end
                // clip at rail and mirror the end point
                S_CLIP: begin
                    r_last <= (r_k == LAST_K);
                    if (w_side) begin
                        r_cx <= w_rail_s;
                        r_rx <= sat_w((SW'(w_rail_s) <<< 1) - SW'(r_ex));
                        r_ry <= r_ey;
                        if (r_dx != '0) begin
                            r_dst   <= DST_CY;
                            r_state <= S_DIVI;
                        end else begin
                            r_cy    <= r_ey;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_cy <= r_rail_tb;
                        r_rx <= r_ex;
                        r_ry <= sat_w((SW'(r_rail_tb) <<< 1) - SW'(r_ey));
                        if (r_dy != '0) begin
                            r_dst   <= DST_CX;
                            r_state <= S_DIVI;
                        end else begin
                            r_cx    <= r_ex;
                            r_state <= S_EMIT;
                        end
                    end
                end
                // bit-serial rounded division
                S_DIVI: begin
                    r_dneg  <= r_prod[PW-1] ^ w_den[DW-1];
                    r_dud   <= w_ud;
                    r_dovf  <= (w_n >> QW) >= NW'(w_ud);
                    r_drem  <= DW'(w_n >> QW);
                    r_dlow  <= w_n[QW-1:0];
                    r_dq    <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    r_drem <= w_ge ? DW'(w_rem2 - {1'b0, r_dud}) : DW'(w_rem2);
                    r_dq   <= {r_dq[QW-2:0], w_ge};
                    r_dlow <= r_dlow << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == CW'(QW - 1)) begin
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    case (r_dst)
                        DST_CX: begin
                            r_cx    <= w_upd;
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_cy    <= w_upd;
                            r_state <= S_EMIT;
                        end
                    endcase
                end
                // output request
                S_EMIT: begin
                    r_osx    <= sat16(r_sx);
                    r_osy    <= sat16(r_sy);
                    r_oex    <= sat16(r_cx);
                    r_oey    <= sat16(r_cy);
                    r_ok     <= r_k;
                    r_oover  <= r_over;
                    r_olast  <= r_last;
                    r_ovalid <= 1'b1;
                    r_state  <= S_WAIT;
                end
                S_WAIT: begin
                    if (!i_out_stall) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sx    <= r_cx;
                            r_sy    <= r_cy;
                            r_ex    <= r_rx;
                            r_ey    <= r_ry;
                            r_k     <= r_k + 1'b1;
                            r_state <= S_CLS;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ports
    assign o_in_stall       = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid      = r_ovalid;
    assign o_seg_start_x    = r_osx;
    assign o_seg_start_y    = r_osy;
    assign o_seg_end_x      = r_oex;
    assign o_seg_end_y      = r_oey;
    assign o_segment_number = r_ok;
    assign o_over_speed     = r_oover;
    assign o_last_segment   = r_olast;

endmodule

`default_nettype wire

>>> tb/ray_bounce_path_in_box_test.sv
// ---------------------------------------------------------------------------
// ray_bounce_path_in_box_test: self-checking bench for the ray bounce block
// Drives shot requests under several rail and gain settings, predicts every
// path segment in a behavioral model and compares each output request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_bounce_path_in_box_test;
    import rbp_pkg::*;

    localparam int SEG_MAX = 8;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic [2:0]         num;
        logic               over;
        logic               last;
    } seg_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_idx = CFG_RAIL_LEFT;
    t_cfg_data   i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_coord16    i_start_x = '0, i_start_y = '0, i_aim_x = '0, i_aim_y = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_coord16    o_seg_start_x, o_seg_start_y, o_seg_end_x, o_seg_end_y;
    t_seg_num    o_segment_number;
    logic        o_over_speed, o_last_segment;

    ray_bounce_path_in_box uut (.*);

    // shadow registers
    longint m_left, m_right, m_top, m_bottom, m_gain, m_limit;
    bit     m_preview;

    seg_t   expected_segs[$];
    int     errors = 0;
    int     n_requests = 0;
    int     n_segments = 0;
    int     idle_pct = 26;
    int     hold_cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    // overall time limit
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // round to nearest, halves away from zero
    function automatic longint div_near(longint num, longint den);
        longint un, ud, q;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = (un + ud / 2) / ud;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // sign of a*dx/dy - b
    function automatic int cross_sign(longint a, longint dx, longint dy, longint b);
        longint p, q;
        p = a * dx;
        q = b * dy;
        if (dy < 0) begin
            p = -p;
            q = -q;
        end
        return p < q ? -1 : (p > q ? 1 : 0);
    endfunction

    function automatic t_hit rail_hit(longint sx, longint sy, longint ex, longint ey);
        longint dx, dy, rail;
        t_hit code;
        dx = ex - sx;
        dy = ey - sy;
        if (ey < m_top) begin
            rail = m_top;
            code = HIT_TOP;
        end else if (ey > m_bottom) begin
            rail = m_bottom;
            code = HIT_BOTTOM;
        end else begin
            if (ex < m_left) return HIT_LEFT;
            if (ex > m_right) return HIT_RIGHT;
            return HIT_NONE;
        end
        if (dy == 0) begin
            if (ex < m_left) return HIT_LEFT;
            if (ex > m_right) return HIT_RIGHT;
            return code;
        end
        if (cross_sign(rail - sy, dx, dy, m_left - sx) < 0) return HIT_LEFT;
        if (cross_sign(rail - sy, dx, dy, m_right - sx) > 0) return HIT_RIGHT;
        return code;
    endfunction

    // trace the bounce path of one shot and queue its segments
    task automatic predict_path(longint stx, longint sty, longint amx, longint amy);
        longint px, py, sx, sy, ex, ey, dx, dy, cx, cy, rx, ry, rail;
        longint unsigned len2, lim, g2;
        bit over, fin;
        t_hit hit;
        seg_t s;
        if (!m_preview) return;
        px = stx - amx;
        py = sty - amy;
        len2 = px * px + py * py;
        lim = (m_limit * 256) * (m_limit * 256);
        g2 = m_gain * m_gain;
        over = g2 * len2 >= lim;
        sx = stx;
        sy = sty;
        ex = sat16(sx + div_near(m_gain * px, 256));
        ey = sat16(sy + div_near(m_gain * py, 256));
        for (int k = 0; k < SEG_MAX; k++) begin
            hit = rail_hit(sx, sy, ex, ey);
            dx = ex - sx;
            dy = ey - sy;
            rx = ex;
            ry = ey;
            fin = (k == SEG_MAX - 1);
            s.sx = 16'(sx); s.sy = 16'(sy); s.num = 3'(k); s.over = over;
            if (hit == HIT_NONE) begin
                s.ex = 16'(ex); s.ey = 16'(ey); s.last = 1'b1;
                expected_segs.push_back(s);
                return;
            end
            if (hit == HIT_LEFT || hit == HIT_RIGHT) begin
                rail = (hit == HIT_LEFT) ? m_left : m_right;
                cx = rail;
                cy = (dx != 0) ? sat16(sy + div_near((rail - sx) * dy, dx)) : ey;
                rx = sat16(2 * rail - ex);
            end else begin
                rail = (hit == HIT_TOP) ? m_top : m_bottom;
                cy = rail;
                cx = (dy != 0) ? sat16(sx + div_near((rail - sy) * dx, dy)) : ex;
                ry = sat16(2 * rail - ey);
            end
            s.ex = 16'(cx); s.ey = 16'(cy); s.last = fin;
            expected_segs.push_back(s);
            if (fin) return;
            sx = cx; sy = cy; ex = rx; ey = ry;
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RAIL_LEFT:   m_left = longint'($signed(val));
            CFG_RAIL_RIGHT:  m_right = longint'($signed(val));
            CFG_RAIL_TOP:    m_top = longint'($signed(val));
            CFG_RAIL_BOTTOM: m_bottom = longint'($signed(val));
            CFG_GAIN:        m_gain = longint'(val[11:0]);
            CFG_SPEED_LIMIT: m_limit = longint'(val);
            CFG_PREVIEW:     m_preview = val[0];
            default: ;
        endcase
    endtask

    // send one shot request, with random idle cycles before it
    task automatic send_shot(logic [15:0] stx, logic [15:0] sty,
                             logic [15:0] amx, logic [15:0] amy);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_start_x = stx;
        i_start_y = sty;
        i_aim_x = amx;
        i_aim_y = amy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_path(longint'($signed(stx)), longint'($signed(sty)),
                     longint'($signed(amx)), longint'($signed(amy)));
        n_requests++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // wait for all segments plus a margin for dropped requests
    task automatic drain;
        int guard;
        guard = 0;
        while (expected_segs.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (400) @(negedge i_clk);
    endtask

    task automatic send_random(int count, int span);
        logic [15:0] a, b;
        for (int i = 0; i < count; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            if ($urandom_range(3) != 0) begin
                // mostly shots starting inside the box with modest pull
                a = 16'($urandom_range(span));
                b = 16'($urandom_range(span / 2));
                send_shot(a, b, 16'(a + $urandom_range(8000) - 4000),
                          16'(b + $urandom_range(8000) - 4000));
            end else begin
                send_shot(a, b, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    // output side: random stall and long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // segment checker
    always @(posedge i_clk) begin
        seg_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_segments++;
            if (expected_segs.size() == 0) begin
                $error("unexpected segment %0d", o_segment_number);
                errors++;
            end else begin
                e = expected_segs.pop_front();
                if (o_seg_start_x !== e.sx) begin
                    $error("seg_start_x exp %0d got %0d", e.sx, o_seg_start_x); errors++;
                end
                if (o_seg_start_y !== e.sy) begin
                    $error("seg_start_y exp %0d got %0d", e.sy, o_seg_start_y); errors++;
                end
                if (o_seg_end_x !== e.ex) begin
                    $error("seg_end_x exp %0d got %0d", e.ex, o_seg_end_x); errors++;
                end
                if (o_seg_end_y !== e.ey) begin
                    $error("seg_end_y exp %0d got %0d", e.ey, o_seg_end_y); errors++;
                end
                if (o_segment_number !== e.num) begin
                    $error("segment_number exp %0d got %0d", e.num, o_segment_number);
                    errors++;
                end
                if (o_over_speed !== e.over) begin
                    $error("over_speed exp %0d got %0d", e.over, o_over_speed); errors++;
                end
                if (o_last_segment !== e.last) begin
                    $error("last_segment exp %0d got %0d", e.last, o_last_segment);
                    errors++;
                end
            end
        end
    end

    // directed shots at default rails: extremes and special cases
    task automatic test_directed;
        send_shot(16'd1000, 16'd1000, 16'd1100, 16'd1050);   // stays inside
        send_shot(16'd8000, 16'd4000, 16'd8000, 16'd6000);   // toward top, vertical, stays inside
        send_shot(16'd8000, 16'd4000, 16'd8000, 16'd2000);   // toward bottom, stays inside
        send_shot(16'd8000, 16'd4000, 16'd10000, 16'd4000);  // toward left, horizontal, stays inside
        send_shot(16'd8000, 16'd4000, 16'd6000, 16'd4000);   // toward right, stays inside
        send_shot(16'd100, 16'd100, 16'd400, 16'd400);       // corner
        send_shot(16'd8000, 16'd4000, 16'd8000, 16'd4000);   // zero pull
        send_shot(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);   // field extremes
        send_shot(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_shot(16'hffff, 16'h0000, 16'h5555, 16'haaaa);
        send_shot(16'd8000, 16'd4000, 16'd7000, 16'd4500);   // diagonal, stays inside
        send_shot(16'd8000, 16'd4000, 16'd9000, 16'd3000);
        drain();
    endtask

    // settings sweep: every register, extremes included
    task automatic test_settings;
        write_reg(CFG_GAIN, 16'd4095);
        write_reg(CFG_SPEED_LIMIT, 16'd0);
        send_shot(16'd8000, 16'd4000, 16'd7990, 16'd4005);
        send_shot(16'd8000, 16'd4000, 16'd8001, 16'd3999);
        drain();
        write_reg(CFG_GAIN, 16'd0);
        write_reg(CFG_SPEED_LIMIT, 16'hffff);
        send_shot(16'd8000, 16'd4000, 16'd100, 16'd100);
        drain();
        // inverted rails
        write_reg(CFG_RAIL_LEFT, 16'd4000);
        write_reg(CFG_RAIL_RIGHT, 16'hf000);
        write_reg(CFG_RAIL_TOP, 16'd3000);
        write_reg(CFG_RAIL_BOTTOM, 16'hf800);
        write_reg(CFG_GAIN, 16'd512);
        write_reg(CFG_SPEED_LIMIT, 16'd3000);
        send_random(6, 8000);
        drain();
        // widest rails
        write_reg(CFG_RAIL_LEFT, 16'h8000);
        write_reg(CFG_RAIL_RIGHT, 16'h7fff);
        write_reg(CFG_RAIL_TOP, 16'h8000);
        write_reg(CFG_RAIL_BOTTOM, 16'h7fff);
        send_random(5, 30000);
        drain();
        // preview off drops requests
        write_reg(CFG_PREVIEW, 16'd0);
        send_shot(16'd1, 16'd2, 16'd3, 16'd4);
        send_shot(16'd500, 16'd500, 16'd0, 16'd0);
        drain();
        write_reg(CFG_PREVIEW, 16'd1);
    endtask

    // random shots in a small box, with the pressure patterns
    task automatic test_random;
        write_reg(CFG_RAIL_LEFT, 16'd200);
        write_reg(CFG_RAIL_RIGHT, 16'd3000);
        write_reg(CFG_RAIL_TOP, 16'd150);
        write_reg(CFG_RAIL_BOTTOM, 16'd1800);
        write_reg(CFG_GAIN, 16'd384);
        write_reg(CFG_SPEED_LIMIT, 16'd1500);
        send_random(30, 3200);
        // long receiver hold-off while shots keep coming
        @(negedge i_clk);
        hold_cycles <= 3000;
        send_random(5, 3200);
        drain();
        // no idling at all
        idle_pct = 0;
        send_random(20, 3200);
        idle_pct = 26;
        // sender pause until every segment is back
        drain();
        write_reg(CFG_GAIN, 16'd256);
        send_random(30, 3200);
        drain();
    endtask

    initial begin
        m_left = RST_RAIL_LEFT;
        m_right = RST_RAIL_RIGHT;
        m_top = RST_RAIL_TOP;
        m_bottom = RST_RAIL_BOTTOM;
        m_gain = RST_GAIN;
        m_limit = RST_SPEED_LIMIT;
        m_preview = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_settings();
        test_random();
        $display("covered %0d shot requests, %0d segments checked", n_requests, n_segments);
        $display("under default, inverted, widest and small-box rails, preview on and off");
        if (errors == 0 && expected_segs.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
